>>> hw/rtl/pfi_pkg.sv
`timescale 1ns / 1ps
package pfi_pkg;

    // Filter geometry
    localparam int RATE           = 6;
    localparam int TOTAL_TAPS     = 48;
    localparam int TAPS_PER_PHASE = TOTAL_TAPS / RATE;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 18;
    localparam int PHASE_BITS     = 3;
    localparam int TAP_BITS       = 3;
    localparam int ROM_IDX_BITS   = 6;

    // Datapath widths
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS    = PROD_BITS + TAP_BITS + 3;
    localparam int ROUND_SHIFT = COEF_BITS - 2;

    localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
        ACC_BITS'(1) <<< (ROUND_SHIFT - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_MAX =
        (ACC_BITS'(1) <<< (SAMPLE_BITS - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] SAT_MIN =
        -(ACC_BITS'(1) <<< (SAMPLE_BITS - 1));

    localparam logic [PHASE_BITS-1:0] LAST_PHASE = PHASE_BITS'(RATE - 1);
    localparam logic [TAP_BITS-1:0]   LAST_TAP   = TAP_BITS'(TAPS_PER_PHASE - 1);

    // Hamming-windowed sinc, cutoff 3600/48000, gain 6, signed Q2.16
    localparam logic signed [COEF_BITS-1:0] COEF_ROM [TOTAL_TAPS] = '{
        -18'sd425,  -18'sd432,  -18'sd364,  -18'sd166,
         18'sd216,   18'sd786,   18'sd1455,  18'sd2020,
         18'sd2196,  18'sd1690,  18'sd315,  -18'sd1893,
        -18'sd4596, -18'sd7146, -18'sd8664, -18'sd8215,
        -18'sd5029,  18'sd1265,  18'sd10478, 18'sd21800,
         18'sd33888, 18'sd45077, 18'sd53692, 18'sd58378,
         18'sd58378, 18'sd53692, 18'sd45077, 18'sd33888,
         18'sd21800, 18'sd10478, 18'sd1265, -18'sd5029,
        -18'sd8215, -18'sd8664, -18'sd7146, -18'sd4596,
        -18'sd1893,  18'sd315,   18'sd1690,  18'sd2196,
         18'sd2020,  18'sd1455,  18'sd786,   18'sd216,
        -18'sd166,  -18'sd364,  -18'sd432,  -18'sd425
    };

    // Tap for a given branch and sample age (age 0 is the newest sample)
    function automatic logic signed [COEF_BITS-1:0] coef_at(
        input logic [PHASE_BITS-1:0] ph,
        input logic [TAP_BITS-1:0]   age
    );
        logic [ROM_IDX_BITS-1:0] idx;
        idx = ROM_IDX_BITS'(ph) + ROM_IDX_BITS'(RATE) * ROM_IDX_BITS'(age);
        return COEF_ROM[idx];
    endfunction

    // Per-cell shift control
    typedef struct packed {
        logic load;
        logic rotate;
    } cell_ctl_t;

    // Control that travels with each product
    typedef struct packed {
        logic                  valid;
        logic                  first;
        logic                  last;
        logic [PHASE_BITS-1:0] phase;
    } mac_ctl_t;

endpackage

>>> hw/rtl/pfi_cell.sv
`timescale 1ns / 1ps
module pfi_cell
    import pfi_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cell_ctl_t                     ctl,
    input  logic signed [SAMPLE_BITS-1:0] load_in,
    input  logic signed [SAMPLE_BITS-1:0] rot_in,
    output logic signed [SAMPLE_BITS-1:0] value
);

    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;

    // Take the newer neighbor on insert, the next cell around the ring on rotate
    always_comb
    begin
        value_next = value_reg;
        if (ctl.load)
        begin
            value_next = load_in;
        end
        else if (ctl.rotate)
        begin
            value_next = rot_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

>>> hw/rtl/pfi_mac.sv
`timescale 1ns / 1ps
module pfi_mac
    import pfi_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  mac_ctl_t                      issue,
    input  logic signed [SAMPLE_BITS-1:0] head,
    input  logic signed [COEF_BITS-1:0]   coef,
    output logic                          done,
    output logic [PHASE_BITS-1:0]         done_phase,
    output logic signed [SAMPLE_BITS-1:0] result
);

    logic signed [PROD_BITS-1:0]  prod_reg;
    logic signed [PROD_BITS-1:0]  prod_next;
    mac_ctl_t                     prod_ctl_reg;
    logic signed [ACC_BITS-1:0]   acc_reg;
    logic signed [ACC_BITS-1:0]   acc_next;
    logic                         done_reg;
    logic                         done_next;
    logic [PHASE_BITS-1:0]        done_phase_reg;
    logic signed [ACC_BITS-1:0]   prod_ext;
    logic signed [ACC_BITS-1:0]   rounded;
    logic signed [ACC_BITS-1:0]   shifted;

    // Multiply stage: widen both operands so the full product is kept
    assign prod_next = PROD_BITS'(head) * PROD_BITS'(coef);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_ctl_reg <= '0;
        end
        else if (adv)
        begin
            prod_ctl_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
        end
    end

    // Accumulate stage: restart on the first tap, flag the sum on the last
    assign prod_ext  = ACC_BITS'(prod_reg);
    assign acc_next  = prod_ctl_reg.first ? prod_ext : acc_reg + prod_ext;
    assign done_next = prod_ctl_reg.valid && prod_ctl_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else if (adv)
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && prod_ctl_reg.valid)
        begin
            acc_reg        <= acc_next;
            done_phase_reg <= prod_ctl_reg.phase;
        end
    end

    // Round half up, then clamp to the sample range
    assign rounded = acc_reg + ROUND_HALF;
    assign shifted = rounded >>> ROUND_SHIFT;

    always_comb
    begin
        if (shifted > SAT_MAX)
        begin
            result = SAT_MAX[SAMPLE_BITS-1:0];
        end
        else if (shifted < SAT_MIN)
        begin
            result = SAT_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            result = shifted[SAMPLE_BITS-1:0];
        end
    end

    assign done       = done_reg;
    assign done_phase = done_phase_reg;

`ifndef SYNTHESIS
    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        prod_ctl_reg.valid && prod_ctl_reg.first |-> !prod_ctl_reg.last)
        else $error("first and last tap flagged on the same product");

    a_done_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        adv && prod_ctl_reg.valid && prod_ctl_reg.last |=> done)
        else $error("final product did not raise done");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        done && !adv |=> done && $stable(result))
        else $error("finished sum changed while held");
`endif

endmodule

>>> hw/rtl/polyphase_interpolator_x6_top.sv
`timescale 1ns / 1ps
// Six-times polyphase FIR interpolator. Each transferred sample_in enters an eight-cell
// ring of history registers, then one shared multiply-accumulate unit walks the ring,
// eight products per branch, and hands out six rounded, saturated samples in branch order
// with last set on the sixth. One input takes 48 products (8 taps by 6 branches), one
// product per cycle through the single multiplier while the output is not held, and
// sample_stall stays high until the last product of the sixth branch has issued; the next
// sample can then transfer while that branch is still in the MAC pipeline. Each branch
// passes the product register, then the accumulator, then the output register. A held
// result freezes the sequencer, the ring and the MAC pipeline. History resets to zeros.
module polyphase_interpolator_x6_top
    import pfi_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic [PHASE_BITS-1:0]         phase,
    output logic                          last
);

    logic                          accept;
    logic                          adv;
    logic                          busy_reg;
    logic                          busy_next;
    logic [PHASE_BITS-1:0]         phase_reg;
    logic [PHASE_BITS-1:0]         phase_next;
    logic [TAP_BITS-1:0]           tap_reg;
    logic [TAP_BITS-1:0]           tap_next;
    cell_ctl_t                     cell_ctl;
    logic signed [SAMPLE_BITS-1:0] cell_val [TAPS_PER_PHASE];
    mac_ctl_t                      issue;
    logic                          mac_done;
    logic [PHASE_BITS-1:0]         mac_phase;
    logic signed [SAMPLE_BITS-1:0] mac_result;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic [PHASE_BITS-1:0]         out_phase_reg;

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = busy_reg;
    assign adv          = !(out_valid_reg && result_stall);

    // Sequence branch and tap counters over one input
    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        tap_next   = tap_reg;
        if (accept)
        begin
            busy_next  = 1'b1;
            phase_next = '0;
            tap_next   = '0;
        end
        else if (busy_reg && adv)
        begin
            tap_next = tap_reg + TAP_BITS'(1);
            if (tap_reg == LAST_TAP)
            begin
                tap_next   = '0;
                phase_next = phase_reg + PHASE_BITS'(1);
                if (phase_reg == LAST_PHASE)
                begin
                    busy_next  = 1'b0;
                    phase_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= '0;
            tap_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            tap_reg   <= tap_next;
        end
    end

    // History ring: insert at cell 0, rotate toward cell 0 while computing
    assign cell_ctl.load   = accept;
    assign cell_ctl.rotate = busy_reg && adv;

    for (genvar i = 0; i < TAPS_PER_PHASE; i++)
    begin : g_cell
        pfi_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (cell_ctl),
            .load_in ((i == 0) ? sample_in : cell_val[(i + TAPS_PER_PHASE - 1) % TAPS_PER_PHASE]),
            .rot_in  (cell_val[(i + 1) % TAPS_PER_PHASE]),
            .value   (cell_val[i])
        );
    end

    // Issue one product per cycle while the output is not held; cell 0 holds the sample of age tap_reg
    assign issue.valid = busy_reg;
    assign issue.first = (tap_reg == '0);
    assign issue.last  = (tap_reg == LAST_TAP);
    assign issue.phase = phase_reg;

    pfi_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .issue      (issue),
        .head       (cell_val[0]),
        .coef       (coef_at(phase_reg, tap_reg)),
        .done       (mac_done),
        .done_phase (mac_phase),
        .result     (mac_result)
    );

    // Output register: load a finished branch, drop valid after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= mac_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && mac_done)
        begin
            out_sample_reg <= mac_result;
            out_phase_reg  <= mac_phase;
        end
    end

    assign result_valid = out_valid_reg;
    assign sample_out   = out_sample_reg;
    assign phase        = out_phase_reg;
    assign last         = (out_phase_reg == LAST_PHASE);

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && tap_reg == '0 && phase_reg == '0)
        else $error("sequencer did not restart on a sample transfer");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> phase_reg <= LAST_PHASE)
        else $error("branch counter out of range");

    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !adv |=> $stable(tap_reg) && $stable(phase_reg) && busy_reg)
        else $error("sequencer advanced while the output was held");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

package tb_interp_pkg;

    import pfi_pkg::SAMPLE_BITS;
    import pfi_pkg::PHASE_BITS;

    localparam int UPSAMPLE        = 6;
    localparam int TAPS_PER_BRANCH = 8;
    localparam int OUT_FRAC        = 16;
    localparam int REPORT_LIMIT    = 10;

    // Hamming-windowed sinc, cutoff 3600/48000, gain 6, Q2.16
    localparam int HAMMING_TAPS [UPSAMPLE*TAPS_PER_BRANCH] = '{
        -425, -432, -364, -166, 216, 786, 1455, 2020,
        2196, 1690, 315, -1893, -4596, -7146, -8664, -8215,
        -5029, 1265, 10478, 21800, 33888, 45077, 53692, 58378,
        58378, 53692, 45077, 33888, 21800, 10478, 1265, -5029,
        -8215, -8664, -7146, -4596, -1893, 315, 1690, 2196,
        2020, 1455, 786, 216, -166, -364, -432, -425
    };

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [PHASE_BITS-1:0]         phase;
        logic                          last;
    } interp_out_t;

    class interp_checker;
        int          history [TAPS_PER_BRANCH];
        int          wr_slot;
        interp_out_t expected_outputs [$];
        int          fault_count;

        function new();
            foreach (history[i])
                history[i] = 0;
            wr_slot     = 0;
            fault_count = 0;
        endfunction

        // Store the transferred sample and queue the six branch outputs it yields
        function void take_sample(logic signed [SAMPLE_BITS-1:0] value);
            longint      acc;
            longint      y;
            int          slot;
            int          tap_idx;
            interp_out_t exp_out;
            history[wr_slot] = int'(value);
            wr_slot = (wr_slot + 1) % TAPS_PER_BRANCH;
            for (int p = 0; p < UPSAMPLE; p++)
            begin
                acc = 0;
                // Oldest sample first; the newest one meets tap p
                for (int j = 0; j < TAPS_PER_BRANCH; j++)
                begin
                    slot    = (wr_slot + j) % TAPS_PER_BRANCH;
                    tap_idx = p + UPSAMPLE * (TAPS_PER_BRANCH - 1 - j);
                    acc += longint'(history[slot]) * longint'(HAMMING_TAPS[tap_idx]);
                end
                // Round half up, then clamp to the output range
                y = (acc + (longint'(1) <<< (OUT_FRAC - 1))) >>> OUT_FRAC;
                if (y > 32767)
                    y = 32767;
                if (y < -32768)
                    y = -32768;
                exp_out.sample_out = SAMPLE_BITS'(y);
                exp_out.phase      = PHASE_BITS'(p);
                exp_out.last       = (p == UPSAMPLE - 1);
                expected_outputs.push_back(exp_out);
            end
        endfunction

        // Compare one transferred output with the oldest expected one
        function void match_output(logic signed [SAMPLE_BITS-1:0] sample_out,
                                   logic [PHASE_BITS-1:0] phase, logic last);
            interp_out_t exp_out;
            if (expected_outputs.size() == 0)
            begin
                if (fault_count < REPORT_LIMIT)
                    $display("ERROR: unexpected output sample_out=%0d phase=%0d last=%0b",
                             sample_out, phase, last);
                fault_count++;
                return;
            end
            exp_out = expected_outputs.pop_front();
            if (sample_out !== exp_out.sample_out || phase !== exp_out.phase ||
                last !== exp_out.last)
            begin
                if (fault_count < REPORT_LIMIT)
                    $display("ERROR: expected sample_out=%0d phase=%0d last=%0b, got %0d %0d %0b",
                             exp_out.sample_out, exp_out.phase, exp_out.last,
                             sample_out, phase, last);
                fault_count++;
            end
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction
    endclass

endpackage

module tb;

    import pfi_pkg::*;
    import tb_interp_pkg::*;

    localparam int RANDOM_ITEMS = 205;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 64;
    localparam int IDLE_PCT     = 8;

    logic                          clk;
    logic                          rst_n;
    logic                          sample_valid;
    logic                          sample_stall;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          result_valid;
    logic                          result_stall;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [PHASE_BITS-1:0]         phase;
    logic                          last;

    interp_checker board;
    logic          quiet;
    int            cycle_count = 0;

    // Extremes, round-trip values, and sign patterns that drive branch 3 into both rails
    int directed_samples [$] = '{
        32767, -32768, 0, 1, -1, 21845, -21846,
        -32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768,
        32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767,
        16384, -16384
    };

    polyphase_interpolator_x6_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_in    (sample_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample_out   (sample_out),
        .phase        (phase),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Abort a run that hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    // Note every input transfer and check every output transfer
    always @(posedge clk)
    begin
        if (rst_n && sample_valid && !sample_stall)
            board.take_sample(sample_in);
        if (rst_n && result_valid && !result_stall)
            board.match_output(sample_out, phase, last);
    end

    // Stall the output side at random, except during the quiet stretch
    initial
    begin
        result_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            result_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Offer one sample from a falling edge and hold it until the transfer
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample_in    <= value;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 4)
            return SAMPLE_BITS'($urandom);
        else if (kind < 7)
            return SAMPLE_BITS'(int'($urandom_range(0, 1023)) - 512);
        else if (kind < 9)
        begin
            case ($urandom_range(0, 4))
                0:       return 16'sh7fff;
                1:       return 16'sh8000;
                2:       return 16'sh0001;
                3:       return 16'shffff;
                default: return 16'sh0000;
            endcase
        end
        else
            return $urandom_range(0, 1) ? 16'sh7fff - SAMPLE_BITS'($urandom_range(0, 255))
                                        : 16'sh8000 + SAMPLE_BITS'($urandom_range(0, 255));
    endfunction

    initial
    begin
        board        = new();
        quiet        = 1'b0;
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample_in    <= '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_samples[i])
            send_sample(SAMPLE_BITS'(directed_samples[i]));

        // Random samples, with a stretch in the middle free of idle cycles
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= 90 && n < 150);
            send_sample(pick_sample());
        end
        quiet = 1'b0;
        sample_valid <= 1'b0;

        // Drain the outstanding outputs, then watch for strays
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.fault_count == 0 && board.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
